FILE: hdl/pea_pkg.sv
`timescale 1ns / 1ps

package pea_pkg;

  // Table size; a power of two, so the symbol index folds by a mask.
  localparam int NUM_SYMBOLS = 1024;
  localparam int IDX_W       = $clog2(NUM_SYMBOLS);

  // Batch epoch tag kept with every entry; tag zero marks an unused entry.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

  // Quotient bits resolved one per cycle below the saturation test.
  localparam int DIV_STEPS = 47;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [62:0]        U63_MAX = {63{1'b1}};
  localparam logic [31:0]        U32_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               new_batch;
    logic [9:0]         symbol_id;
    logic signed [23:0] quantity;
    logic [31:0]        price;
  } pos_t;

  typedef struct packed {
    logic signed [47:0] symbol_quantity;
    logic signed [63:0] symbol_notional;
    logic [31:0]        symbol_count;
    logic signed [47:0] symbol_mean_price;
    logic [62:0]        long_exposure;
    logic [62:0]        short_exposure;
    logic signed [63:0] net_notional;
    logic [31:0]        position_total;
  } res_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic signed [47:0] quantity;
    logic signed [63:0] notional;
    logic [31:0]        count;
    logic signed [47:0] mean_px;
  } entry_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic wipe;
    logic read;
    logic upd;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic wipe_last;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] sym_index(input logic [9:0] id);
    logic [31:0] wide;
    wide = 32'(id) % NUM_SYMBOLS;
    return IDX_W'(wide);
  endfunction

endpackage

FILE: hdl/position_exposure_aggregator_top.sv
`timescale 1ns / 1ps

// Position exposure aggregator.
// Input channel pos/pos_valid/pos_ready carries one trade position per
// transaction: batch flag, symbol index, signed quantity, unsigned price.
// Output channel res/res_valid/res_ready returns one transaction per
// position: the symbol's updated entry and the batch exposure totals.
// One position is worked at a time. The divider that forms the average
// price resolves one quotient bit per cycle.
// The symbol table sits in one RAM, each entry tagged with a batch epoch;
// a new batch bumps the epoch rather than clearing the table. Every 255th
// batch the epoch wraps and a sweep retags all 1024 entries before that
// position. After reset the same sweep runs with pos_ready held low.
// The result sits in an output register; while the receiver stalls it is
// held, the next position may still be accepted and worked, and that
// position waits in its final step until the register frees.
module position_exposure_aggregator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          pos_valid,
  output logic          pos_ready,
  input  pea_pkg::pos_t pos,
  output logic          res_valid,
  input  logic          res_ready,
  output pea_pkg::res_t res
);

  pea_pkg::cmd_t cmd;
  pea_pkg::sts_t sts;

  // sequencing of each transaction
  pea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .pos_valid(pos_valid),
    .pos_ready(pos_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, totals, multiplier, divider and output register
  pea_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .pos      (pos),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // one position in flight: drop ready right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    pos_valid && pos_ready |=> !pos_ready)
    else $error("second transaction accepted while one is in flight");

  // the table sweep never overlaps input acceptance
  a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (rst)
    cmd.wipe |-> !pos_ready)
    else $error("input ready during table sweep");

  // finishing loads the output register
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("finished transaction not presented");

  // a divider restart never coincides with its completion
  a_div_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done straight after start");

endmodule

FILE: hdl/pea_ram.sv
`timescale 1ns / 1ps

module pea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pea_div.sv
`timescale 1ns / 1ps

module pea_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [47:0] den,
  output logic               done,
  output logic signed [47:0] quo
);

  logic                       busy;
  logic [pea_pkg::DIV_CNT_W-1:0] cnt;
  logic [47:0]                dmag;
  logic [47:0]                rem;
  logic [46:0]                low;
  logic [46:0]                q;
  logic                       neg;
  logic                       sat;

  logic [63:0] nmag;
  logic [47:0] dmag_in;
  logic [16:0] hi;
  logic [48:0] trial;
  logic [48:0] diff;
  logic        ge;
  logic [47:0] qext;

  assign nmag    = num[63] ? 64'(-num) : 64'(num);
  assign dmag_in = den[47] ? 48'(-den) : 48'(den);
  assign hi      = nmag[63:47];
  assign trial   = {rem, low[46]};
  assign diff    = trial - {1'b0, dmag};
  assign ge      = trial >= {1'b0, dmag};
  assign qext    = {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pea_pkg::DIV_CNT_W'(pea_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pea_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient of 2^47 or more saturates; test it up front, then restore bitwise.
  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= dmag_in;
      neg  <= num[63] ^ den[47];
      sat  <= {31'b0, hi} >= dmag_in;
      rem  <= {31'b0, hi};
      low  <= nmag[46:0];
      q    <= '0;
    end else if (busy) begin
      rem <= ge ? diff[47:0] : trial[47:0];
      low <= {low[45:0], 1'b0};
      q   <= {q[45:0], ge};
    end
  end

  always_comb begin
    if (sat) begin
      quo = neg ? pea_pkg::Q48_MIN : pea_pkg::Q48_MAX;
    end else begin
      quo = neg ? 48'(-$signed(qext)) : $signed(qext);
    end
  end

endmodule

FILE: hdl/pea_datapath.sv
`timescale 1ns / 1ps

module pea_datapath (
  input  logic            clk,
  input  logic            rst,
  input  pea_pkg::cmd_t   cmd,
  output pea_pkg::sts_t   sts,
  input  pea_pkg::pos_t   pos,
  output logic            res_valid,
  input  logic            res_ready,
  output pea_pkg::res_t   res
);

  localparam int IW = pea_pkg::IDX_W;

  // held transaction
  logic                      nb;
  logic [IW-1:0]             idx;
  logic signed [23:0]        qty;
  logic [31:0]               price;
  logic signed [63:0]        notional;

  logic [pea_pkg::EPOCH_W-1:0] epoch;
  logic [IW-1:0]             wipe_cnt;

  logic [62:0]               long_sum;
  logic [62:0]               short_sum;
  logic signed [63:0]        net_sum;
  logic [31:0]               count_sum;

  logic signed [47:0]        e_qty;
  logic signed [63:0]        e_not;
  logic [31:0]               e_cnt;
  logic signed [47:0]        e_avg_old;

  pea_pkg::entry_t           rdata;
  pea_pkg::entry_t           wdata;
  logic                      we;
  logic [IW-1:0]             waddr;

  logic                      div_done;
  logic signed [47:0]        div_quo;

  // update arithmetic
  logic                      hit;
  logic signed [47:0]        o_qty;
  logic signed [63:0]        o_not;
  logic [31:0]               o_cnt;
  logic signed [47:0]        o_avg;
  logic signed [48:0]        qsum;
  logic signed [64:0]        nsum;
  logic signed [64:0]        tsum;
  logic [63:0]               nmag;
  logic [63:0]               lsum;
  logic [63:0]               ssum;
  logic signed [56:0]        prod;
  logic signed [47:0]        avg_new;

  assign prod = 57'(qty) * 57'($signed({1'b0, price}));

  assign hit   = rdata.tag == epoch;
  assign o_qty = hit ? rdata.quantity  : '0;
  assign o_not = hit ? rdata.notional  : '0;
  assign o_cnt = hit ? rdata.count     : '0;
  assign o_avg = hit ? rdata.mean_px   : '0;
  assign qsum  = 49'(o_qty) + 49'(qty);
  assign nsum  = 65'(o_not) + 65'(notional);
  assign tsum  = 65'(net_sum) + 65'(notional);
  assign nmag  = notional[63] ? 64'(-notional) : 64'(notional);
  assign lsum  = {1'b0, long_sum} + nmag;
  assign ssum  = {1'b0, short_sum} + nmag;

  assign avg_new = (e_qty != '0) ? div_quo : e_avg_old;

  assign sts.wrap      = nb && (epoch == pea_pkg::EPOCH_LAST);
  assign sts.wipe_last = wipe_cnt == IW'(pea_pkg::NUM_SYMBOLS - 1);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !res_valid || res_ready;

  always_comb begin
    wdata = '0;
    if (cmd.wipe) begin
      we    = 1'b1;
      waddr = wipe_cnt;
      wdata.tag = pea_pkg::EPOCH_NONE;
    end else begin
      we    = cmd.finish;
      waddr = idx;
      wdata.tag       = epoch;
      wdata.quantity  = e_qty;
      wdata.notional  = e_not;
      wdata.count     = e_cnt;
      wdata.mean_px   = avg_new;
    end
  end

  pea_ram #(
    .WIDTH($bits(pea_pkg::entry_t)),
    .DEPTH(pea_pkg::NUM_SYMBOLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.read),
    .raddr(idx),
    .rdata(rdata)
  );

  pea_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (e_not),
    .den  (e_qty),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= pea_pkg::EPOCH_FIRST;
      wipe_cnt  <= '0;
      long_sum  <= '0;
      short_sum <= '0;
      net_sum   <= '0;
      count_sum <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.wipe) begin
        wipe_cnt <= sts.wipe_last ? '0 : wipe_cnt + 1'b1;
      end
      if (cmd.mul && nb) begin
        epoch     <= sts.wrap ? pea_pkg::EPOCH_FIRST : epoch + 1'b1;
        long_sum  <= '0;
        short_sum <= '0;
        net_sum   <= '0;
        count_sum <= '0;
      end
      if (cmd.upd) begin
        if (!notional[63] && notional != '0) begin
          long_sum <= lsum[63] ? pea_pkg::U63_MAX : lsum[62:0];
        end else begin
          short_sum <= ssum[63] ? pea_pkg::U63_MAX : ssum[62:0];
        end
        if (tsum[64] != tsum[63]) begin
          net_sum <= tsum[64] ? pea_pkg::S64_MIN : pea_pkg::S64_MAX;
        end else begin
          net_sum <= tsum[63:0];
        end
        if (count_sum != pea_pkg::U32_MAX) begin
          count_sum <= count_sum + 1'b1;
        end
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nb    <= pos.new_batch;
      idx   <= pea_pkg::sym_index(pos.symbol_id);
      qty   <= pos.quantity;
      price <= pos.price;
    end
    if (cmd.mul) begin
      notional <= 64'(prod);
    end
    if (cmd.upd) begin
      if (qsum[48] != qsum[47]) begin
        e_qty <= qsum[48] ? pea_pkg::Q48_MIN : pea_pkg::Q48_MAX;
      end else begin
        e_qty <= qsum[47:0];
      end
      if (nsum[64] != nsum[63]) begin
        e_not <= nsum[64] ? pea_pkg::S64_MIN : pea_pkg::S64_MAX;
      end else begin
        e_not <= nsum[63:0];
      end
      e_cnt     <= (o_cnt == pea_pkg::U32_MAX) ? o_cnt : o_cnt + 1'b1;
      e_avg_old <= o_avg;
    end
    if (cmd.finish) begin
      res.symbol_quantity   <= e_qty;
      res.symbol_notional   <= e_not;
      res.symbol_count      <= e_cnt;
      res.symbol_mean_price <= avg_new;
      res.long_exposure     <= long_sum;
      res.short_exposure    <= short_sum;
      res.net_notional      <= net_sum;
      res.position_total    <= count_sum;
    end
  end

endmodule

FILE: hdl/pea_ctrl.sv
`timescale 1ns / 1ps

module pea_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          pos_valid,
  output logic          pos_ready,
  input  pea_pkg::sts_t sts,
  output pea_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_WIPE = 9'b000001000,
    S_READ = 9'b000010000,
    S_UPD  = 9'b000100000,
    S_DIVS = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign pos_ready = state == S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.load      = pos_ready && pos_valid;
    cmd.mul       = state == S_MUL;
    cmd.wipe      = (state == S_INIT) || (state == S_WIPE);
    cmd.read      = state == S_READ;
    cmd.upd       = state == S_UPD;
    cmd.div_start = state == S_DIVS;
    cmd.finish    = (state == S_DONE) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sts.wipe_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pos_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = sts.wrap ? S_WIPE : S_READ;
      end
      S_WIPE: begin
        if (sts.wipe_last) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_DIVS;
      end
      S_DIVS: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
